/* rtl/qlbs_pkg.sv */
package qlbs_pkg;

   // lane and word widths
   localparam int LaneW = 16;
   localparam int VecW  = 48;
   localparam int QuatW = 64;
   localparam int SumW  = 32;

   // action codes
   localparam logic ActLoad   = 1'b0;
   localparam logic ActWeight = 1'b1;

   typedef logic signed [LaneW-1:0] lane_type;
   typedef logic signed [SumW-1:0]  sum_type;

   // saturating add of two 32-bit sums
   function automatic sum_type sat_add(input sum_type a, input sum_type b);
      logic signed [SumW:0] s;
      s = {a[SumW-1], a} + {b[SumW-1], b};
      if (s > $signed({1'b0, {(SumW-1){1'b1}}}))
         sat_add = {1'b0, {(SumW-1){1'b1}}};
      else if (s < $signed({1'b1, 1'b1, {(SumW-1){1'b0}}}))
         sat_add = {1'b1, {(SumW-1){1'b0}}};
      else
         sat_add = s[SumW-1:0];
   endfunction

   // saturate a sum to one 16-bit lane
   function automatic lane_type sat16(input sum_type a);
      if (a > 32'sd32767)
         sat16 = 16'sh7fff;
      else if (a < -32'sd32768)
         sat16 = 16'sh8000;
      else
         sat16 = a[LaneW-1:0];
   endfunction

endpackage

/* rtl/quaternion_linear_blend_skinning_unit.sv */
// quaternion linear blend skinning unit
//
// req channel: one transfer per item. a load item (tuser action = 0) writes one
// joint's location and quaternion into the pose memory. a weight item reads its
// joint, rotates offset, normal and tangent by the joint quaternion, adds the
// joint location to the offset, scales all by the bias and adds into nine
// vertex sums. tlast on a weight closes the vertex.
// rsp channel: one transfer per vertex with the nine sums, each saturated to a lane.
//
// the pose memory is read at the edge that takes a weight; the weight then
// passes five stages: pose register, first product, second product with
// rounding, bias scale and sum update. the block takes no new transfer until
// the weight has left the sum update stage, and a closing weight's result is
// moved on from that stage. loads stay in the idle state, so an item may follow.
// reset clears the sums and the control state; the pose memory is undefined
// until loaded. when rsp stalls, the result waits in the output register; a
// second finished vertex waits in a holding register and the block then takes
// no transfer until the output register is free.
module quaternion_linear_blend_skinning_unit
   import qlbs_pkg::*;
#(
   parameter int MAX_JOINTS = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // joint_index[7:0], vector_position[55:8], joint_quaternion[119:56],
   // weight_normal[167:120], weight_tangent[215:168], weight_bias[231:216]
   input  logic [231:0] req_tdata,
   input  logic         req_tuser,  // action
   input  logic         req_tlast,  // last_weight
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // skinned_position[47:0], skinned_normal[95:48], skinned_tangent[143:96]
   output logic [143:0] rsp_tdata
);

   localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

   // sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_MUL1 = 3'd2;
   localparam logic [2:0] S_MUL2 = 3'd3;
   localparam logic [2:0] S_BIAS = 3'd4;
   localparam logic [2:0] S_ACC  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;

   // unpacked request fields
   logic [7:0]      joint;
   logic [VecW-1:0] vpos, nrm, tng;
   logic [QuatW-1:0] quat;
   logic [15:0]     bias;
   assign joint = req_tdata[7:0];
   assign vpos  = req_tdata[55:8];
   assign quat  = req_tdata[119:56];
   assign nrm   = req_tdata[167:120];
   assign tng   = req_tdata[215:168];
   assign bias  = req_tdata[231:216];

   logic in_range;
   assign in_range = ({24'd0, joint} < 32'(MAX_JOINTS));

   logic [AW-1:0] addr;
   assign addr = AW'(joint);

   // pose memory
   logic [VecW+QuatW-1:0] pose_mem [MAX_JOINTS];
   logic [VecW+QuatW-1:0] pose_rd_ff;

   // item registers
   logic signed [15:0] v_ff [9];     // offset, normal, tangent lanes
   logic [15:0]        bias_ff;
   logic               last_ff, valid_j_ff;
   logic signed [15:0] q_ff [4];
   logic signed [15:0] loc_ff [3];
   logic signed [33:0] t_ff [9];     // first products
   logic signed [33:0] d_ff [3];
   logic signed [32:0] c_ff [9];     // bias scaled
   sum_type            sum_ff [9];
   logic [143:0]       rsp_data_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [143:0]       rsp_data_pend;
   logic [143:0]       rsp_pack_now;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   logic acc_fire;
   assign acc_fire = (state_ff == S_ACC);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = (req_tuser == ActWeight) ? S_READ : S_IDLE;
         S_READ: state_in = S_MUL1;
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_BIAS;
         S_BIAS: state_in = S_ACC;
         S_ACC:  state_in = (last_ff && rsp_valid_ff && !rsp_tready) ? S_OUT : S_IDLE;
         S_OUT:  state_in = (!rsp_valid_ff || rsp_tready) ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // memory write and read
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready && req_tuser == ActLoad && in_range)
         pose_mem[addr] <= {quat, vpos};
      pose_rd_ff <= pose_mem[addr];
   end

   // capture item
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         for (int i = 0; i < 3; i++) begin
            v_ff[i]   <= vpos[16*i +: 16];
            v_ff[3+i] <= nrm[16*i +: 16];
            v_ff[6+i] <= tng[16*i +: 16];
         end
         bias_ff    <= bias;
         last_ff    <= req_tlast;
         valid_j_ff <= in_range;
      end
   end

   // pose register, then first product stage: t = w v + u x v, d = u.v
   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         for (int i = 0; i < 4; i++)
            q_ff[i] <= valid_j_ff ? pose_rd_ff[VecW+16*i +: 16] : 16'sd0;
         for (int i = 0; i < 3; i++)
            loc_ff[i] <= valid_j_ff ? pose_rd_ff[16*i +: 16] : 16'sd0;
      end
      if (state_ff == S_MUL1) begin
         for (int b = 0; b < 3; b++) begin
            t_ff[3*b]   <= q_ff[3]*v_ff[3*b]   + q_ff[1]*v_ff[3*b+2] - q_ff[2]*v_ff[3*b+1];
            t_ff[3*b+1] <= q_ff[3]*v_ff[3*b+1] + q_ff[2]*v_ff[3*b]   - q_ff[0]*v_ff[3*b+2];
            t_ff[3*b+2] <= q_ff[3]*v_ff[3*b+2] + q_ff[0]*v_ff[3*b+1] - q_ff[1]*v_ff[3*b];
            d_ff[b] <= q_ff[0]*v_ff[3*b] + q_ff[1]*v_ff[3*b+1] + q_ff[2]*v_ff[3*b+2];
         end
      end
   end

   // second product stage: r = w t + d u + u x t, rounded by 2^28
   logic signed [53:0] rr [9];
   logic signed [25:0] rs [9];
   always_comb begin
      for (int b = 0; b < 3; b++) begin
         rr[3*b]   = q_ff[3]*t_ff[3*b]   + d_ff[b]*q_ff[0]
                     + q_ff[1]*t_ff[3*b+2] - q_ff[2]*t_ff[3*b+1];
         rr[3*b+1] = q_ff[3]*t_ff[3*b+1] + d_ff[b]*q_ff[1]
                     + q_ff[2]*t_ff[3*b]   - q_ff[0]*t_ff[3*b+2];
         rr[3*b+2] = q_ff[3]*t_ff[3*b+2] + d_ff[b]*q_ff[2]
                     + q_ff[0]*t_ff[3*b+1] - q_ff[1]*t_ff[3*b];
      end
      for (int i = 0; i < 9; i++)
         rs[i] = 26'((rr[i] + 54'sd134217728) >>> 28);
   end

   logic signed [25:0] rl [9];
   always_comb begin
      for (int i = 0; i < 9; i++)
         rl[i] = (i < 3) ? rs[i] + 26'(loc_ff[i % 3]) : rs[i];
   end

   // rotated lanes stay in 26 bits; keep them whole for the bias stage
   logic signed [25:0] rw_ff [9];
   always_ff @(posedge clock) begin
      if (state_ff == S_MUL2)
         for (int i = 0; i < 9; i++) rw_ff[i] <= rl[i];
   end

   // bias scale, rounded by 2^15
   logic signed [42:0] pm [9];
   always_comb begin
      for (int i = 0; i < 9; i++)
         pm[i] = rw_ff[i] * $signed({1'b0, bias_ff});
   end
   always_ff @(posedge clock) begin
      if (state_ff == S_BIAS)
         for (int i = 0; i < 9; i++)
            c_ff[i] <= 33'((pm[i] + 43'sd16384) >>> 15);
   end

   // sum update and result
   sum_type cs [9];
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         if (c_ff[i] > 33'sd2147483647)       cs[i] = sat_add(sum_ff[i], 32'sh7fffffff);
         else if (c_ff[i] < -33'sd2147483648) cs[i] = sat_add(sum_ff[i], 32'sh80000000);
         else                                 cs[i] = sat_add(sum_ff[i], c_ff[i][31:0]);
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) rsp_pack_now[16*i +: 16] = sat16(cs[i]);
   end

   logic can_emit;
   assign can_emit = !rsp_valid_ff || rsp_tready;

   logic load_out;
   assign load_out = ((acc_fire && last_ff) || state_ff == S_OUT) && can_emit;

   // output valid: held until taken, raised when a result moves in
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) sum_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (acc_fire) begin
            for (int i = 0; i < 9; i++) sum_ff[i] <= last_ff ? '0 : cs[i];
            if (last_ff) rsp_data_pend <= rsp_pack_now;
         end
      end
   end

   // result staging: pending word is copied out once the output register is free
   always_ff @(posedge clock) begin
      if (load_out)
         rsp_data_ff <= (state_ff == S_OUT) ? rsp_data_pend : rsp_pack_now;
   end

endmodule

/* rtl/qlbs_checker.sv */
module qlbs_checker
   import qlbs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata
);

   // a stalled result holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a load never raises a result next cycle from nothing
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ActLoad && !rsp_tvalid |=> !rsp_tvalid)
      else $error("load produced a result");

   // after a weight transfer the block is busy next cycle
   a_weight_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ActWeight |=> !req_tready)
      else $error("weight not held off");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");

endmodule

bind quaternion_linear_blend_skinning_unit qlbs_checker u_qlbs_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

/* verif/skinning_checker.sv */
module skinning_checker
   import qlbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [231:0] req_tdata,
   input  logic         req_tuser,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [143:0] rsp_tdata,
   output int           error_count,
   output int           vertices_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int JointCount = 256;

   logic [VecW-1:0]  joint_location [JointCount];
   logic [QuatW-1:0] joint_rotation [JointCount];
   longint           blend_sums [9];
   logic [143:0]     vertex_queue [$];

   function automatic longint lane_of(input logic [63:0] word, input int lane);
      logic signed [15:0] v;
      v = word[16*lane +: 16];
      return longint'(v);
   endfunction

   // floor((x + 2^(n-1)) / 2^n)
   function automatic longint round_down(input longint x, input int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint clamp(input longint x, input longint lo, input longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   // rotate v by q and round back to the lane format
   task automatic rotate_by_joint(input longint v[3], input longint q[4],
                                  output longint r[3]);
      longint t[3];
      longint d;
      longint f[3];
      t[0] = q[3]*v[0] + (q[1]*v[2] - q[2]*v[1]);
      t[1] = q[3]*v[1] + (q[2]*v[0] - q[0]*v[2]);
      t[2] = q[3]*v[2] + (q[0]*v[1] - q[1]*v[0]);
      d = q[0]*v[0] + q[1]*v[1] + q[2]*v[2];
      f[0] = q[3]*t[0] + d*q[0] + (q[1]*t[2] - q[2]*t[1]);
      f[1] = q[3]*t[1] + d*q[1] + (q[2]*t[0] - q[0]*t[2]);
      f[2] = q[3]*t[2] + d*q[2] + (q[0]*t[1] - q[1]*t[0]);
      for (int i = 0; i < 3; i++) r[i] = round_down(f[i], 28);
   endtask

   // apply one transfer on the request channel to the predicted state
   task automatic skin_item(input logic act, input logic [231:0] d, input logic last);
      logic [7:0]       jnt;
      logic [VecW-1:0]  loc_w;
      logic [QuatW-1:0] rot_w;
      longint           q[4];
      longint           vin[3][3];
      longint           vout[3][3];
      longint           bias;
      longint           c;
      logic [143:0]     word;
      jnt = d[7:0];
      if (act == ActLoad) begin
         joint_location[jnt] = d[55:8];
         joint_rotation[jnt] = d[119:56];
         return;
      end
      loc_w = joint_location[jnt];
      rot_w = joint_rotation[jnt];
      bias = longint'(d[231:216]);
      for (int i = 0; i < 4; i++) q[i] = lane_of(rot_w, i);
      for (int i = 0; i < 3; i++) begin
         vin[0][i] = lane_of({16'd0, d[55:8]}, i);
         vin[1][i] = lane_of({16'd0, d[167:120]}, i);
         vin[2][i] = lane_of({16'd0, d[215:168]}, i);
      end
      for (int k = 0; k < 3; k++) rotate_by_joint(vin[k], q, vout[k]);
      for (int i = 0; i < 3; i++) vout[0][i] += lane_of({16'd0, loc_w}, i);
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++) begin
            c = round_down(vout[k][i] * bias, 15);
            blend_sums[3*k+i] = clamp(blend_sums[3*k+i] + c,
                                      -64'sd2147483648, 64'sd2147483647);
         end
      if (last) begin
         for (int s = 0; s < 9; s++) begin
            word[16*s +: 16] = 16'(clamp(blend_sums[s], -32768, 32767));
            blend_sums[s] = 0;
         end
         vertex_queue = {vertex_queue, word};
      end
   endtask

   // watch both channels
   always @(posedge clock) begin
      logic [143:0] want;
      if (reset) begin
         for (int s = 0; s < 9; s++) blend_sums[s] = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (vertex_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected vertex %h", rsp_tdata);
            end else begin
               want = vertex_queue.pop_front();
               for (int f = 0; f < 3; f++)
                  if (rsp_tdata[48*f +: 48] !== want[48*f +: 48]) begin
                     error_count++;
                     if (error_count <= 10)
                        $display("field %0d mismatch: expected %h actual %h",
                                 f, want[48*f +: 48], rsp_tdata[48*f +: 48]);
                  end
            end
         end
         if (req_tvalid && req_tready) skin_item(req_tuser, req_tdata, req_tlast);
      end
      vertices_pending = vertex_queue.size();
   end

   initial begin
      error_count = 0;
      vertices_pending = 0;
   end
endmodule

/* verif/tb.sv */
module tb
   import qlbs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock;
   logic         reset;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [231:0] req_tdata = '0;
   logic         req_tuser = 0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [143:0] rsp_tdata;
   int           error_count;
   int           vertices_pending;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           cycle_count;
   bit           loaded [256];
   logic [7:0]   loaded_list [$];

   quaternion_linear_blend_skinning_unit dut (.*);

   skinning_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (8) @(posedge clock);
      reset <= 0;
   end

   // receiver stalls
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // one transfer on the request channel; valid stays up until the next call
   task automatic send_item(input logic act, input logic [7:0] jnt,
                            input logic [47:0] pos, input logic [63:0] quat,
                            input logic [47:0] nrm, input logic [47:0] tng,
                            input logic [15:0] bias, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= act;
      req_tlast <= last;
      req_tdata <= {bias, tng, nrm, quat, pos, jnt};
      if (act == ActLoad && !loaded[jnt]) begin
         loaded[jnt] = 1;
         loaded_list = {loaded_list, jnt};
      end
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_load();
      send_item(ActLoad, 8'($urandom()), 48'(rand64()), rand64(), 48'(rand64()),
                48'(rand64()), 16'($urandom()), 1'($urandom()));
   endtask

   // one vertex of 1..4 weights over loaded joints
   task automatic random_vertex();
      int n;
      logic [15:0] b;
      n = $urandom_range(4, 1);
      for (int w = 0; w < n; w++) begin
         b = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(32768));
         send_item(ActWeight, loaded_list[$urandom_range(loaded_list.size() - 1)],
                   48'(rand64()), rand64(), 48'(rand64()), 48'(rand64()), b, w == n - 1);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (vertices_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      send_idle_pct = 26;
      recv_idle_pct = 62;
      @(negedge reset);
      @(posedge clock);
      // directed: extremes, identity, scaled rotation, load with last marker
      send_item(ActLoad, 8'd0, 48'h0, {16'sd16384, 48'h0}, '0, '0, '0, 1'b1);
      send_item(ActLoad, 8'd255, {3{16'h7fff}}, {4{16'h8000}}, '0, '0, '0, 1'b0);
      send_item(ActLoad, 8'd7, {3{16'h8000}}, {4{16'h7fff}}, '0, '0, '0, 1'b1);
      send_item(ActLoad, 8'd9, 48'h0001_fffe_0040, 64'h1234_c000_4000_0000,
                '0, '0, '0, 1'b0);
      send_item(ActWeight, 8'd0, 48'h0003_0002_0001, '0, 48'h0000_0000_4000,
                48'h0000_4000_0000, 16'd32768, 1'b1);
      send_item(ActWeight, 8'd255, {3{16'h7fff}}, '1, {3{16'h7fff}},
                {3{16'h8000}}, 16'hffff, 1'b0);
      send_item(ActWeight, 8'd255, {3{16'h7fff}}, '0, {3{16'h7fff}},
                {3{16'h7fff}}, 16'hffff, 1'b1);
      send_item(ActWeight, 8'd7, {3{16'h8000}}, '0, {3{16'h8000}},
                {3{16'h8000}}, 16'hffff, 1'b0);
      send_item(ActWeight, 8'd7, {3{16'h8000}}, '0, {3{16'h7fff}},
                {3{16'h0001}}, 16'd0, 1'b1);
      send_item(ActWeight, 8'd9, 48'hffff_0100_8001, '0, 48'h1111_eeee_2222,
                48'h7fff_0000_8000, 16'd16384, 1'b0);
      send_item(ActWeight, 8'd0, 48'h0, '0, '0, '0, 16'd1, 1'b1);
      // hold off until everything has come back
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 62;
            recv_idle_pct = 26;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int k = 0; k < 70; k++) begin
            if ($urandom_range(3) == 0) random_load();
            else random_vertex();
         end
      end
      drain();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
